// ===== hdl/button_press_led_timeout_assert.svh =====
// assertion macros for the button press led timeout block
`ifndef BUTTON_PRESS_LED_TIMEOUT_ASSERT_SVH
`define BUTTON_PRESS_LED_TIMEOUT_ASSERT_SVH

`ifndef ASSERT_OFF

`define BPLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BPLT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BPLT_ASSERT(label, prop, msg)

`define BPLT_NEVER(label, cond, msg)

`endif

`endif

// ===== hdl/bplt_pkg.sv =====
// types and constants shared by the button press led timeout block
`default_nettype none

package bplt_pkg;

    localparam int unsigned DEBOUNCE_W = 10;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned EVENT_W    = 3;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 10'd50;
    localparam logic [MS_W-1:0]       LONG_PRESS_RESET = 16'd2000;
    localparam logic [MS_W-1:0]       TIMEOUT_RESET    = 16'd10000;
    localparam logic [MS_W-1:0]       MS_SAT           = {MS_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_EDGE = 1'b1;
    localparam logic LEVEL_PRESSED = 1'b0;

    localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PRESS       = 3'd1;
    localparam logic [EVENT_W-1:0] EV_ON          = 3'd2;
    localparam logic [EVENT_W-1:0] EV_RESTART     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LONG_OFF    = 3'd4;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT_OFF = 3'd5;
    localparam logic [EVENT_W-1:0] EV_DEBOUNCED   = 3'd6;

    typedef struct packed {
        logic kind;
        logic level;
    } item_t;

    typedef struct packed {
        logic               led_on;
        logic [EVENT_W-1:0] event_res;
    } result_t;

    function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v);
        logic [MS_W-1:0] r;
        r = (v == MS_SAT) ? MS_SAT : v + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/button_press_led_timeout.sv =====
// short/long press detector with a retriggerable led timer
//
// item channel: item_valid / item_stall / item. each item is a 1 ms tick
// (kind 0) or a button edge (kind 1) carrying the sampled level, 0 pressed.
// result channel: result_valid / result_stall / result. every item gives
// exactly one result: the led drive after the item and an event code.
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready;
// index 0 debounce time, 1 long press time, 2 led on time, others ignored.
// an accepted item's result is registered and shown in the next cycle.
// throughput is one item per cycle while item_stall is low; the state
// update and result are one compare-and-update between the state and the
// result register. while result_stall holds a pending result, item_stall is
// raised, so items wait; the pending result holds. a drained result frees the
// register in the same cycle, so back to back items flow with no bubble.
// reset clears all counters, loads the register defaults (50, 2000, 10000)
// and sets the since-edge count saturated, so the first edge is accepted.
`default_nettype none

`include "button_press_led_timeout_assert.svh"

module button_press_led_timeout
    import bplt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [MS_W-1:0]       cfg_data
);

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [MS_W-1:0]       long_press_reg;
    logic [MS_W-1:0]       timeout_reg;

    logic [MS_W-1:0] since_reg, since_next;
    logic            pressing_reg, pressing_next;
    logic [MS_W-1:0] held_reg, held_next;
    logic            led_lit_reg, led_lit_next;
    logic [MS_W-1:0] remaining_reg, remaining_next;

    logic            result_valid_reg;
    result_t         result_reg, result_next;

    logic            accept;
    logic [EVENT_W-1:0] ev;
    logic [MS_W-1:0] held_inc;
    logic [MS_W-1:0] timeout_load;

    assign cfg_ready    = 1'b1;
    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign held_inc     = sat_inc(held_reg);
    // a zero timeout acts as one
    assign timeout_load = (timeout_reg == '0) ? {{(MS_W-1){1'b0}}, 1'b1} : timeout_reg;

    always_comb
    begin
        since_next     = since_reg;
        pressing_next  = pressing_reg;
        held_next      = held_reg;
        led_lit_next   = led_lit_reg;
        remaining_next = remaining_reg;
        ev             = EV_NONE;

        if (item.kind == KIND_TICK)
        begin
            since_next = sat_inc(since_reg);
            if (led_lit_reg)
            begin
                if (remaining_reg <= {{(MS_W-1){1'b0}}, 1'b1})
                begin
                    remaining_next = '0;
                    led_lit_next   = 1'b0;
                    ev             = EV_TIMEOUT_OFF;
                end
                else
                begin
                    remaining_next = remaining_reg - 1'b1;
                end
            end
            if (pressing_reg)
            begin
                held_next = held_inc;
                // long press wins over a timeout on the same tick
                if (held_inc >= long_press_reg)
                begin
                    led_lit_next   = 1'b0;
                    remaining_next = '0;
                    pressing_next  = 1'b0;
                    ev             = EV_LONG_OFF;
                end
            end
        end
        else if (since_reg < {{(MS_W-DEBOUNCE_W){1'b0}}, debounce_reg})
        begin
            ev = EV_DEBOUNCED;
        end
        else
        begin
            since_next = '0;
            if (item.level == LEVEL_PRESSED)
            begin
                pressing_next = 1'b1;
                held_next     = '0;
                ev            = EV_PRESS;
            end
            else if (pressing_reg)
            begin
                pressing_next = 1'b0;
                if (held_reg < long_press_reg)
                begin
                    ev             = led_lit_reg ? EV_RESTART : EV_ON;
                    led_lit_next   = 1'b1;
                    remaining_next = timeout_load;
                end
            end
        end

        result_next.led_on    = led_lit_next;
        result_next.event_res = ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data[DEBOUNCE_W-1:0];
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_TIMEOUT:    timeout_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg     <= MS_SAT;
            pressing_reg  <= 1'b0;
            held_reg      <= '0;
            led_lit_reg   <= 1'b0;
            remaining_reg <= '0;
        end
        else if (accept)
        begin
            since_reg     <= since_next;
            pressing_reg  <= pressing_next;
            held_reg      <= held_next;
            led_lit_reg   <= led_lit_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    `BPLT_ASSERT(a_lit_has_time, led_lit_reg == (remaining_reg != '0), "led and timer disagree")
    `BPLT_ASSERT(a_accept_gives_result, accept |=> result_valid, "accepted item gave no result")
    `BPLT_ASSERT(a_result_led_tracks_state, result_valid |-> result.led_on == led_lit_reg, "led")
    `BPLT_NEVER(a_long_off_lit, result_valid && result == {1'b1, EV_LONG_OFF}, "long off lit")

endmodule

`default_nettype wire
